// File: hw/rtl/thumbnail_source_address_gen_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the thumbnail source address generator
// Clocked, reset-gated property checks used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef THUMBNAIL_SOURCE_ADDRESS_GEN_ASSERT_SVH
`define THUMBNAIL_SOURCE_ADDRESS_GEN_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define TSAG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define TSAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tsag_pkg.sv
// ---------------------------------------------------------------------------
// tsag_pkg
// Types, widths and constants shared by the thumbnail source address gen.
// ---------------------------------------------------------------------------
`default_nettype none

package tsag_pkg;

  // Thumbnail geometry
  localparam int THUMB_WIDTH  = 128;
  localparam int THUMB_HEIGHT = 80;

  // Field widths
  localparam int CFG_W   = 13;
  localparam int COORD_W = 7;
  localparam int ADDR_W  = 24;
  localparam int SRC_W   = 12;
  localparam int TIDX_W  = 14;
  localparam int AX_W    = 15;            // signed rectangle edge / span
  localparam int PROD_W  = COORD_W + CFG_W; // coordinate times span
  localparam int MULA_W  = 2 * CFG_W;       // row times pitch

  // Row scale: floor(p / THUMB_HEIGHT) = (p * RECIP) >> DIV_SH for p < 2**PROD_W
  localparam int     TH_LOG  = $clog2(THUMB_HEIGHT);
  localparam int     DIV_SH  = PROD_W + TH_LOG;
  localparam int     RECIP_W = PROD_W + 1;
  localparam longint RECIP_L = ((64'sd1 <<< DIV_SH) + THUMB_HEIGHT - 1) / THUMB_HEIGHT;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  // Pipeline depth: input reg through output reg
  localparam int STAGES = 7;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_VIEW_LEFT    = 3'd2,
    REG_VIEW_TOP     = 3'd3,
    REG_VIEW_SPAN_X  = 3'd4,
    REG_VIEW_SPAN_Y  = 3'd5,
    REG_CROP_WIDTH   = 3'd6
  } cfg_reg_t;

  // Beat payloads
  typedef struct packed {
    logic [COORD_W-1:0] thumb_col;
    logic [COORD_W-1:0] thumb_row;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] source_addr;
    logic [SRC_W-1:0]  source_col;
    logic [SRC_W-1:0]  source_row;
    logic [TIDX_W-1:0] thumb_index;
    logic              rect_ok;
  } out_beat_t;

  // One axis of the view rectangle before clamping
  typedef struct packed {
    logic signed [AX_W-1:0] pos;
    logic signed [AX_W-1:0] len;
  } axis_t;

  // One axis after clamping to the framebuffer
  typedef struct packed {
    logic             ok;
    logic [CFG_W-1:0] pos;
    logic [CFG_W-1:0] len;
  } span_t;

endpackage

`default_nettype wire

// File: hw/rtl/tsag_axis_clamp.sv
// ---------------------------------------------------------------------------
// tsag_axis_clamp
// Clamps one axis of the view rectangle to [0, limit) and flags empty spans.
// ---------------------------------------------------------------------------
`default_nettype none

module tsag_axis_clamp (
  input  tsag_pkg::axis_t           ax_i,
  input  logic [tsag_pkg::CFG_W-1:0] limit_i,
  output tsag_pkg::span_t           span_o
);
  import tsag_pkg::*;

  logic signed [AX_W:0] pos_e;
  logic signed [AX_W:0] len_e;
  logic signed [AX_W:0] p1;
  logic signed [AX_W:0] l1;
  logic signed [AX_W:0] end_s;
  logic signed [AX_W:0] lim_s;
  logic signed [AX_W:0] l2;

  always_comb begin
    pos_e = {ax_i.pos[AX_W-1], ax_i.pos};
    len_e = {ax_i.len[AX_W-1], ax_i.len};
    lim_s = {{(AX_W+1-CFG_W){1'b0}}, limit_i};

    // left/top edge off screen: pull it in and shorten the span
    if (pos_e < 0) begin
      p1 = '0;
      l1 = len_e + pos_e;
    end else begin
      p1 = pos_e;
      l1 = len_e;
    end

    // far edge past the frame: cut the span
    end_s = p1 + l1;
    l2    = (end_s > lim_s) ? (lim_s - p1) : l1;

    span_o.ok  = (l2 > 0);
    span_o.pos = p1[CFG_W-1:0];
    span_o.len = l2[CFG_W-1:0];
  end

endmodule

`default_nettype wire

// File: hw/rtl/thumbnail_source_address_gen.sv
// ---------------------------------------------------------------------------
// thumbnail_source_address_gen
// Nearest-neighbor source address for one thumbnail pixel per beat.
// ---------------------------------------------------------------------------
// Usage:
//   cfg channel: write registers by index (cfg_valid/cfg_ready, always
//   ready) while no beat is in flight. in channel: one thumbnail
//   coordinate per beat. out channel: source address, source column and
//   row, thumbnail index and the rect_ok flag, one beat per input beat,
//   in order.
//   An accepted beat reaches out_valid through every stage register; the
//   pipeline takes one beat per cycle while in_stall is low. The depth is
//   set by the two chained multiplies (span scale with reciprocal divide,
//   then the row pitch multiply), each followed by a register.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   registers with a 320x200 frame, a matching view and no crop.
//   When out_stall is high the output register holds; stages behind it
//   keep filling bubbles, and in_stall rises only once every stage is full.
// ---------------------------------------------------------------------------
`default_nettype none

module thumbnail_source_address_gen (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tsag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsag_pkg::CFG_W-1:0]     cfg_data,
  // input beats
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tsag_pkg::in_beat_t             in_data,
  // result beats
  output logic                           out_valid,
  input  logic                           out_stall,
  output tsag_pkg::out_beat_t            out_data
);
  import tsag_pkg::*;

  `include "thumbnail_source_address_gen_assert.svh"

  // ---------------- configuration registers ----------------
  logic [CFG_W-1:0] frame_width_r, frame_height_r;
  logic [CFG_W-1:0] view_left_r, view_top_r;
  logic [CFG_W-1:0] view_span_x_r, view_span_y_r;
  logic [CFG_W-1:0] crop_width_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_W'(320);
      frame_height_r <= CFG_W'(200);
      view_left_r    <= '0;
      view_top_r     <= '0;
      view_span_x_r  <= CFG_W'(320);
      view_span_y_r  <= CFG_W'(200);
      crop_width_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_VIEW_LEFT:    view_left_r    <= cfg_data;
        REG_VIEW_TOP:     view_top_r     <= cfg_data;
        REG_VIEW_SPAN_X:  view_span_x_r  <= cfg_data;
        REG_VIEW_SPAN_Y:  view_span_y_r  <= cfg_data;
        REG_CROP_WIDTH:   crop_width_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  // a stage loads when it is empty or the stage ahead loads
  logic [STAGES:1] vld_r, vld_nxt;
  logic [STAGES:1] en;

  always_comb begin
    en[STAGES] = !vld_r[STAGES] || !out_stall;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt = vld_r;
    if (en[1]) vld_nxt[1] = in_valid;
    for (int k = 2; k <= STAGES; k++) begin
      if (en[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld_r[STAGES];

  // ---------------- stage 1: saturate coordinates, crop ----------------
  logic [COORD_W-1:0] col_nxt, row_nxt;
  logic [TIDX_W-1:0]  tidx_nxt;
  logic [CFG_W-1:0]   crop_diff;
  logic               crop_on;
  logic signed [AX_W-1:0] vl_ext, vt_ext;
  axis_t              ax_x_nxt, ax_y_nxt;

  always_comb begin
    col_nxt = (32'(in_data.thumb_col) >= THUMB_WIDTH) ?
              COORD_W'(THUMB_WIDTH - 1) : in_data.thumb_col;
    row_nxt = (32'(in_data.thumb_row) >= THUMB_HEIGHT) ?
              COORD_W'(THUMB_HEIGHT - 1) : in_data.thumb_row;
    tidx_nxt = TIDX_W'(32'(row_nxt) * THUMB_WIDTH + 32'(col_nxt));

    vl_ext = {{(AX_W-CFG_W){view_left_r[CFG_W-1]}}, view_left_r};
    vt_ext = {{(AX_W-CFG_W){view_top_r[CFG_W-1]}}, view_top_r};

    // centered crop to the narrower width
    crop_on   = (crop_width_r != '0) && (view_span_x_r > crop_width_r);
    crop_diff = view_span_x_r - crop_width_r;
    if (crop_on) begin
      ax_x_nxt.pos = vl_ext + $signed({{(AX_W-CFG_W+1){1'b0}}, crop_diff[CFG_W-1:1]});
      ax_x_nxt.len = $signed({{(AX_W-CFG_W){1'b0}}, crop_width_r});
    end else begin
      ax_x_nxt.pos = vl_ext;
      ax_x_nxt.len = $signed({{(AX_W-CFG_W){1'b0}}, view_span_x_r});
    end
    ax_y_nxt.pos = vt_ext;
    ax_y_nxt.len = $signed({{(AX_W-CFG_W){1'b0}}, view_span_y_r});
  end

  logic [COORD_W-1:0] s1_col_r, s1_row_r;
  logic [TIDX_W-1:0]  s1_tidx_r;
  axis_t              s1_ax_x_r, s1_ax_y_r;

  // ---------------- stage 2: clamp to framebuffer ----------------
  span_t sp_x_nxt, sp_y_nxt;

  tsag_axis_clamp u_clamp_x (
    .ax_i    (s1_ax_x_r),
    .limit_i (frame_width_r),
    .span_o  (sp_x_nxt)
  );

  tsag_axis_clamp u_clamp_y (
    .ax_i    (s1_ax_y_r),
    .limit_i (frame_height_r),
    .span_o  (sp_y_nxt)
  );

  logic [COORD_W-1:0] s2_col_r, s2_row_r;
  logic [TIDX_W-1:0]  s2_tidx_r;
  span_t              s2_sp_x_r, s2_sp_y_r;

  // ---------------- stage 3: scale spans by coordinate ----------------
  logic [PROD_W-1:0]  s3_px_r, s3_py_r;
  logic [CFG_W-1:0]   s3_x0_r, s3_y0_r;
  logic               s3_ok_r;
  logic [TIDX_W-1:0]  s3_tidx_r;

  // ---------------- stage 4: column sum, row reciprocal multiply --------
  logic [CFG_W-1:0]          s4_sx_r, s4_y0_r;
  logic [PROD_W+RECIP_W-1:0] s4_qm_r;
  logic                      s4_ok_r;
  logic [TIDX_W-1:0]         s4_tidx_r;

  // ---------------- stage 5: row sum ----------------
  logic [CFG_W-1:0]  s5_sx_r, s5_sy_r;
  logic              s5_ok_r;
  logic [TIDX_W-1:0] s5_tidx_r;

  // ---------------- stage 6: row times pitch ----------------
  logic [MULA_W-1:0] s6_prod_r;
  logic [CFG_W-1:0]  s6_sx_r, s6_sy_r;
  logic              s6_ok_r;
  logic [TIDX_W-1:0] s6_tidx_r;

  // ---------------- stage 7: output register ----------------
  out_beat_t out_r, out_nxt;

  always_comb begin
    out_nxt.thumb_index = s6_tidx_r;
    out_nxt.rect_ok     = s6_ok_r;
    if (s6_ok_r) begin
      out_nxt.source_addr = ADDR_W'(s6_prod_r + MULA_W'(s6_sx_r));
      out_nxt.source_col  = s6_sx_r[SRC_W-1:0];
      out_nxt.source_row  = s6_sy_r[SRC_W-1:0];
    end else begin
      out_nxt.source_addr = '0;
      out_nxt.source_col  = '0;
      out_nxt.source_row  = '0;
    end
  end

  // payload registers, each gated by its stage enable
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_col_r  <= col_nxt;
      s1_row_r  <= row_nxt;
      s1_tidx_r <= tidx_nxt;
      s1_ax_x_r <= ax_x_nxt;
      s1_ax_y_r <= ax_y_nxt;
    end
    if (en[2]) begin
      s2_col_r  <= s1_col_r;
      s2_row_r  <= s1_row_r;
      s2_tidx_r <= s1_tidx_r;
      s2_sp_x_r <= sp_x_nxt;
      s2_sp_y_r <= sp_y_nxt;
    end
    if (en[3]) begin
      s3_px_r   <= PROD_W'(s2_col_r) * PROD_W'(s2_sp_x_r.len);
      s3_py_r   <= PROD_W'(s2_row_r) * PROD_W'(s2_sp_y_r.len);
      s3_x0_r   <= s2_sp_x_r.pos;
      s3_y0_r   <= s2_sp_y_r.pos;
      s3_ok_r   <= s2_sp_x_r.ok && s2_sp_y_r.ok;
      s3_tidx_r <= s2_tidx_r;
    end
    if (en[4]) begin
      s4_sx_r   <= CFG_W'(s3_x0_r + CFG_W'(s3_px_r / THUMB_WIDTH));
      s4_qm_r   <= (PROD_W+RECIP_W)'(s3_py_r) * (PROD_W+RECIP_W)'(RECIP);
      s4_y0_r   <= s3_y0_r;
      s4_ok_r   <= s3_ok_r;
      s4_tidx_r <= s3_tidx_r;
    end
    if (en[5]) begin
      s5_sx_r   <= s4_sx_r;
      s5_sy_r   <= CFG_W'(s4_y0_r + CFG_W'(s4_qm_r >> DIV_SH));
      s5_ok_r   <= s4_ok_r;
      s5_tidx_r <= s4_tidx_r;
    end
    if (en[6]) begin
      s6_prod_r <= MULA_W'(s5_sy_r) * MULA_W'(frame_width_r);
      s6_sx_r   <= s5_sx_r;
      s6_sy_r   <= s5_sy_r;
      s6_ok_r   <= s5_ok_r;
      s6_tidx_r <= s5_tidx_r;
    end
    if (en[7]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // ---------------- assertions ----------------
  `TSAG_ASSERT_SAME(a_empty_rect_zero, clk, rst_n, out_valid && !out_data.rect_ok, (out_data.source_addr == '0) && (out_data.source_col == '0) && (out_data.source_row == '0), "empty rectangle must give zero source fields")
  `TSAG_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && !in_stall, vld_r[1], "accepted beat missing from first stage")
  `TSAG_ASSERT_SAME(a_stall_only_full, clk, rst_n, in_stall, (&vld_r) && out_stall, "input stalled while pipeline has a bubble")

endmodule

`default_nettype wire
